// File: hdl/blsk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsk_pkg
// Shared types and codes of the bounded LIFO stack core.
// ----------------------------------------------------------------------------
package blsk_pkg;

    // Command codes
    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_PEEK    = 2'd2;
    localparam logic [1:0] CMD_DISPLAY = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    // Register map
    localparam int         PADDR_W         = 3;
    localparam logic       REG_MAX_ENTRIES = 1'b0;
    localparam logic [6:0] MAX_ENTRIES_RST = 7'd64;

    // Longest display run, and with it the largest usable capacity
    localparam int RUN_LIMIT = 64;
    localparam int ADDR_W    = 6;

    localparam logic signed [31:0] EMPTY_WORD = -32'sd1;
    localparam logic signed [31:0] ZERO_WORD  = 32'sd0;

    // What the back end does with one queued operation
    typedef enum logic [1:0] {
        K_DIRECT,   // result fully formed by the front end
        K_WRITE,    // store word, report it
        K_READ      // report the stored word at addr
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [ADDR_W-1:0]        addr;
        logic signed [31:0]       word;
        logic [1:0]               status;
        logic [6:0]               occ;
        logic                     last;
    } t_op;

endpackage

// File: hdl/blsk_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsk_cmd_if
// Command channel: valid/ready with command code and push word.
// ----------------------------------------------------------------------------
interface blsk_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

// File: hdl/blsk_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsk_rsp_if
// Result channel: valid/ready with word, status, occupancy and last flag.
// ----------------------------------------------------------------------------
interface blsk_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic [6:0]         occupancy;
    logic               last;

    modport source (output valid, output value, output status, output occupancy,
                    output last, input ready);
    modport sink   (input valid, input value, input status, input occupancy,
                    input last, output ready);
endinterface

// File: hdl/blsk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsk_front
// Accept commands, track occupancy and turn each command into queued
// operations; sequence display runs one entry per cycle, queue allowing.
// ----------------------------------------------------------------------------
module blsk_front #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    blsk_cmd_if.sink          i_cmd,
    input  logic [6:0]        i_max_entries,
    input  logic              i_q_full,
    output logic              o_op_valid,
    output blsk_pkg::t_op     o_op
);

    localparam int BOUND = (DEPTH < blsk_pkg::RUN_LIMIT) ? DEPTH : blsk_pkg::RUN_LIMIT;
    localparam int CW    = $clog2(BOUND + 1);
    localparam int AW    = $clog2(BOUND);
    localparam int OAW   = blsk_pkg::ADDR_W;

    typedef enum logic {
        S_ACCEPT,
        S_RUN
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx,   n_idx;

    logic [6:0]      cap;
    logic [6:0]      count7;
    logic [CW-1:0]   count_m1;
    logic            full;
    logic            empty;
    logic            accept;

    always_comb begin
        // Saturate capacity to 1 .. BOUND
        if (i_max_entries == 7'd0) begin
            cap = 7'd1;
        end else if (i_max_entries > 7'(BOUND)) begin
            cap = 7'(BOUND);
        end else begin
            cap = i_max_entries;
        end
        count7   = 7'(r_count);
        count_m1 = r_count - CW'(1);
        full     = (count7 >= cap);
        empty    = (r_count == '0);

        i_cmd.ready = (r_state == S_ACCEPT) && !i_q_full;
        accept      = i_cmd.valid && i_cmd.ready;

        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        o_op_valid = 1'b0;
        o_op.kind   = blsk_pkg::K_DIRECT;
        o_op.addr   = '0;
        o_op.word   = i_cmd.push_value;
        o_op.status = blsk_pkg::ST_OK;
        o_op.occ    = count7;
        o_op.last   = 1'b1;

        case (r_state)
            S_ACCEPT: begin
                if (accept) begin
                    o_op_valid = 1'b1;
                    case (i_cmd.command)
                        blsk_pkg::CMD_PUSH: begin
                            if (full) begin
                                o_op.status = blsk_pkg::ST_OVERFLOW;
                            end else begin
                                o_op.kind = blsk_pkg::K_WRITE;
                                o_op.addr = OAW'(r_count);
                                o_op.occ  = 7'(r_count + CW'(1));
                                n_count   = r_count + CW'(1);
                            end
                        end
                        blsk_pkg::CMD_POP: begin
                            if (empty) begin
                                o_op.word   = blsk_pkg::EMPTY_WORD;
                                o_op.status = blsk_pkg::ST_EMPTY;
                                o_op.occ    = 7'd0;
                            end else begin
                                o_op.kind = blsk_pkg::K_READ;
                                o_op.addr = OAW'(count_m1);
                                o_op.occ  = 7'(count_m1);
                                n_count   = count_m1;
                            end
                        end
                        blsk_pkg::CMD_PEEK: begin
                            if (empty) begin
                                o_op.word   = blsk_pkg::EMPTY_WORD;
                                o_op.status = blsk_pkg::ST_EMPTY;
                                o_op.occ    = 7'd0;
                            end else begin
                                o_op.kind = blsk_pkg::K_READ;
                                o_op.addr = OAW'(count_m1);
                            end
                        end
                        default: begin
                            if (empty) begin
                                o_op.word   = blsk_pkg::ZERO_WORD;
                                o_op.status = blsk_pkg::ST_EMPTY;
                                o_op.occ    = 7'd0;
                            end else begin
                                // First entry of the run goes out now
                                o_op.kind = blsk_pkg::K_READ;
                                o_op.addr = OAW'(count_m1);
                                o_op.last = (r_count == CW'(1));
                                if (r_count != CW'(1)) begin
                                    n_state = S_RUN;
                                    n_idx   = AW'(r_count - CW'(2));
                                end
                            end
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (!i_q_full) begin
                    o_op_valid = 1'b1;
                    o_op.kind  = blsk_pkg::K_READ;
                    o_op.addr  = OAW'(r_idx);
                    o_op.last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_ACCEPT;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

endmodule

// File: hdl/blsk_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsk_queue
// Two-entry operation queue between the front and back ends.
// ----------------------------------------------------------------------------
module blsk_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  blsk_pkg::t_op     i_op,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output blsk_pkg::t_op     o_op
);

    blsk_pkg::t_op r_slot [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_op    = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// File: hdl/blsk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsk_back
// Carry out queued operations on the entry memory and hold each result
// in the output register until it is taken.
// ----------------------------------------------------------------------------
module blsk_back #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  blsk_pkg::t_op     i_op,
    output logic              o_q_pop,
    blsk_rsp_if.source        o_rsp
);

    localparam int BOUND = (DEPTH < blsk_pkg::RUN_LIMIT) ? DEPTH : blsk_pkg::RUN_LIMIT;
    localparam int AW    = $clog2(BOUND);

    logic signed [31:0] r_mem [BOUND];
    logic signed [31:0] r_rdata;
    blsk_pkg::t_op      r_op;
    logic               r_valid;
    logic               adv;

    assign adv     = !r_valid || o_rsp.ready;
    assign o_q_pop = i_q_valid && adv;

    // Entry memory: one write and one registered read per cycle, on a pop
    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_op.kind == blsk_pkg::K_WRITE)) begin
            r_mem[i_op.addr[AW-1:0]] <= i_op.word;
        end
        if (o_q_pop) begin
            r_rdata <= r_mem[i_op.addr[AW-1:0]];
            r_op    <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_q_valid;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.value     = (r_op.kind == blsk_pkg::K_READ) ? r_rdata : r_op.word;
    assign o_rsp.status    = r_op.status;
    assign o_rsp.occupancy = r_op.occ;
    assign o_rsp.last      = r_op.last;

endmodule

// File: hdl/bounded_lifo_stack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_lifo_stack_core
// Bounded LIFO stack of signed 32-bit words with push, pop, peek and
// display commands and an APB-style capacity register.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  i_cmd     in         valid/ready         command, push_value
//  o_rsp     out        valid/ready         value, status, occupancy, last
//  apb       in/out     psel/penable/pready max_entries at byte address 0
//
//  Push, pop and peek: one command per cycle while the queue has room; each
//  result passes the queue, then the memory read into the output register.
//  Display: one result per stored entry (a single one on an empty stack),
//  read in turn via the entry memory's one read port; commands wait meanwhile.
//  Reset (synchronous, active low): stack empty, max_entries = 64. Entries
//  are not cleared; only entries below the occupancy are ever read.
//  A stalled result holds in the output register; the queue keeps taking
//  commands until both of its slots are occupied.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_core #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    blsk_cmd_if.sink                      i_cmd,
    blsk_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blsk_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Capacity register
    logic [6:0]    r_max_entries;
    logic          reg_hit;

    // Front to queue, queue to back
    logic          f_op_valid;
    blsk_pkg::t_op f_op;
    logic          q_full;
    logic          q_valid;
    blsk_pkg::t_op q_op;
    logic          q_pop;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == blsk_pkg::REG_MAX_ENTRIES);
    assign prdata  = reg_hit ? {25'd0, r_max_entries} : 32'd0;

    // Write on the access phase; addresses beyond the register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= blsk_pkg::MAX_ENTRIES_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_max_entries <= pwdata[6:0];
        end
    end

    // Front end: classify commands, own the occupancy, sequence displays
    blsk_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_max_entries (r_max_entries),
        .i_q_full      (q_full),
        .o_op_valid    (f_op_valid),
        .o_op          (f_op)
    );

    // Decoupling queue
    blsk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_op_valid),
        .i_op    (f_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    // Back end: entry memory and output register
    blsk_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (q_op),
        .o_q_pop   (q_pop),
        .o_rsp     (o_rsp)
    );

endmodule

// File: hdl/blsk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsk_checker
// Port-level checks on the result channel of the stack core.
// ----------------------------------------------------------------------------
module blsk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic signed [31:0] i_value,
    input logic [1:0]         i_status,
    input logic [6:0]         i_occupancy,
    input logic               i_last
);

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // A stalled result holds its word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_value))
        else $error("stalled result changed");

    // Empty status is a single result on an empty stack
    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == blsk_pkg::ST_EMPTY) |-> i_last && (i_occupancy == 7'd0))
        else $error("empty result malformed");

    // Overflow only on a non-empty stack, as a single result
    a_overflow_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == blsk_pkg::ST_OVERFLOW) |-> i_last && (i_occupancy != 7'd0))
        else $error("overflow result malformed");

endmodule

bind bounded_lifo_stack_core blsk_checker u_blsk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_value     (o_rsp.value),
    .i_status    (o_rsp.status),
    .i_occupancy (o_rsp.occupancy),
    .i_last      (o_rsp.last)
);
